>>> hw/rtl/rca_pkg.sv
// ----------------------------------------------------------------------------
// rca_pkg
// Shared types, widths, op codes and register indexes for the residue
// channel arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rca_pkg;

   localparam int RCA_CHANNELS  = 4;
   localparam int RCA_RES_BITS  = 16;
   localparam int RCA_VAL_BITS  = 32;
   // dividend width of the final reduction: a full product or a binary value
   localparam int RCA_RED_BITS  = (2 * RCA_RES_BITS > RCA_VAL_BITS) ?
                                  2 * RCA_RES_BITS : RCA_VAL_BITS;
   // operand reduction, op stage, final reduction
   localparam int RCA_LANE_LAT  = RCA_RES_BITS + 1 + RCA_RED_BITS;
   localparam int RCA_CSR_BITS  = 3;
   localparam int RCA_CNT_BITS  = 3;

   localparam logic [1:0] OP_CONVERT  = 2'd0;
   localparam logic [1:0] OP_ADD      = 2'd1;
   localparam logic [1:0] OP_SUBTRACT = 2'd2;
   localparam logic [1:0] OP_MULTIPLY = 2'd3;

   localparam logic [RCA_CSR_BITS-1:0] REG_MODULUS_0     = 3'd0;
   localparam logic [RCA_CSR_BITS-1:0] REG_MODULI_IN_USE = 3'd4;

   localparam logic [RCA_CNT_BITS-1:0] MODULI_IN_USE_RESET = 3'd4;

   typedef struct packed {
      logic [1:0]              op;
      logic [RCA_VAL_BITS-1:0] binary_value;
      logic [RCA_RES_BITS-1:0] lhs_res_0;
      logic [RCA_RES_BITS-1:0] lhs_res_1;
      logic [RCA_RES_BITS-1:0] lhs_res_2;
      logic [RCA_RES_BITS-1:0] lhs_res_3;
      logic [RCA_RES_BITS-1:0] rhs_res_0;
      logic [RCA_RES_BITS-1:0] rhs_res_1;
      logic [RCA_RES_BITS-1:0] rhs_res_2;
      logic [RCA_RES_BITS-1:0] rhs_res_3;
   } req_data_type;

   typedef struct packed {
      logic [RCA_RES_BITS-1:0] out_res_0;
      logic [RCA_RES_BITS-1:0] out_res_1;
      logic [RCA_RES_BITS-1:0] out_res_2;
      logic [RCA_RES_BITS-1:0] out_res_3;
   } rsp_data_type;

   function automatic logic [RCA_RES_BITS-1:0] modulus_reset(input int idx);
      logic [RCA_RES_BITS-1:0] val;
      case (idx)
         0: val = RCA_RES_BITS'(251);
         1: val = RCA_RES_BITS'(253);
         2: val = RCA_RES_BITS'(255);
         default: val = RCA_RES_BITS'(256);
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/rca_modred.sv
// ----------------------------------------------------------------------------
// rca_modred
// Pipelined restoring remainder: one dividend bit per stage, MSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module rca_modred import rca_pkg::*; #(
   parameter int DIV_BITS = RCA_VAL_BITS,
   parameter int RES_BITS = RCA_RES_BITS
) (
   input  wire logic                clock,
   input  wire logic                enable,
   input  wire logic [DIV_BITS-1:0] dividend,
   input  wire logic [RES_BITS-1:0] modulus,
   output logic      [RES_BITS-1:0] remainder
);

   logic [RES_BITS-1:0] rem_ff [DIV_BITS];
   logic [DIV_BITS-1:0] div_ff [DIV_BITS];

   genvar k;
   generate
      for (k = 0; k < DIV_BITS; k++) begin : g_stage
         logic [RES_BITS-1:0] rem_prev;
         logic [DIV_BITS-1:0] div_prev;
         logic [RES_BITS:0]   trial;
         logic [RES_BITS:0]   diff;
         logic [RES_BITS-1:0] rem_in;

         if (k == 0) begin : g_first
            assign rem_prev = '0;
            assign div_prev = dividend;
         end else begin : g_next
            assign rem_prev = rem_ff[k-1];
            assign div_prev = div_ff[k-1];
         end

         always_comb begin
            trial = {rem_prev, div_prev[DIV_BITS-1-k]};
            diff  = trial - {1'b0, modulus};
            if (trial >= {1'b0, modulus}) begin
               rem_in = diff[RES_BITS-1:0];
            end else begin
               rem_in = trial[RES_BITS-1:0];
            end
         end

         always_ff @(posedge clock) begin
            if (enable) begin
               rem_ff[k] <= rem_in;
               div_ff[k] <= div_prev;
            end
         end
      end
   endgenerate

   assign remainder = rem_ff[DIV_BITS-1];

endmodule

`default_nettype wire

>>> hw/rtl/rca_lane.sv
// ----------------------------------------------------------------------------
// rca_lane
// One residue channel: reduce operands, apply the op, reduce the result.
// ----------------------------------------------------------------------------
`default_nettype none

module rca_lane import rca_pkg::*; #(
   parameter int RES_BITS = RCA_RES_BITS,
   parameter int VAL_BITS = RCA_VAL_BITS,
   parameter int RED_BITS = RCA_RED_BITS
) (
   input  wire logic                clock,
   input  wire logic                enable,
   input  wire logic [1:0]          op,
   input  wire logic [VAL_BITS-1:0] value,
   input  wire logic [RES_BITS-1:0] lhs,
   input  wire logic [RES_BITS-1:0] rhs,
   input  wire logic [RES_BITS-1:0] modulus,
   output logic      [RES_BITS-1:0] result
);

   logic [RES_BITS-1:0]   lhs_red;
   logic [RES_BITS-1:0]   rhs_red;
   logic [1:0]            op_ff  [RES_BITS];
   logic [VAL_BITS-1:0]   val_ff [RES_BITS];
   logic [RED_BITS-1:0]   dvd_ff;
   logic [RED_BITS-1:0]   dvd_in;
   logic [2*RES_BITS-1:0] prod;
   logic [RES_BITS:0]     sum;
   logic [RES_BITS:0]     dif;

   rca_modred #(.DIV_BITS(RES_BITS), .RES_BITS(RES_BITS)) u_red_lhs (
      .clock(clock), .enable(enable), .dividend(lhs), .modulus(modulus),
      .remainder(lhs_red)
   );

   rca_modred #(.DIV_BITS(RES_BITS), .RES_BITS(RES_BITS)) u_red_rhs (
      .clock(clock), .enable(enable), .dividend(rhs), .modulus(modulus),
      .remainder(rhs_red)
   );

   // op and value ride alongside the operand reduction
   always_ff @(posedge clock) begin
      if (enable) begin
         for (int i = 0; i < RES_BITS; i++) begin
            if (i == 0) begin
               op_ff[i]  <= op;
               val_ff[i] <= value;
            end else begin
               op_ff[i]  <= op_ff[i-1];
               val_ff[i] <= val_ff[i-1];
            end
         end
      end
   end

   // sums stay below 2m, so the final reduction finishes them too
   always_comb begin
      prod = {{RES_BITS{1'b0}}, lhs_red} * {{RES_BITS{1'b0}}, rhs_red};
      sum  = {1'b0, lhs_red} + {1'b0, rhs_red};
      dif  = {1'b0, lhs_red} + {1'b0, modulus} - {1'b0, rhs_red};
      case (op_ff[RES_BITS-1])
         OP_CONVERT:  dvd_in = RED_BITS'(val_ff[RES_BITS-1]);
         OP_ADD:      dvd_in = RED_BITS'(sum);
         OP_SUBTRACT: dvd_in = RED_BITS'(dif);
         default:     dvd_in = RED_BITS'(prod);
      endcase
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         dvd_ff <= dvd_in;
      end
   end

   rca_modred #(.DIV_BITS(RED_BITS), .RES_BITS(RES_BITS)) u_red_out (
      .clock(clock), .enable(enable), .dividend(dvd_ff), .modulus(modulus),
      .remainder(result)
   );

endmodule

`default_nettype wire

>>> hw/rtl/rns_channel_arithmetic_top.sv
// ----------------------------------------------------------------------------
// rns_channel_arithmetic_top
// Residue arithmetic over four configurable moduli: convert, add,
// subtract, multiply.
// ----------------------------------------------------------------------------
// One request per cycle is taken while the output is not stalled; each result
// passes through 16 operand reduction stages, one op stage, 32 result
// reduction stages and the output register. Latency is set by the bit-serial
// remainder pipelines, one dividend bit per stage, in every lane. The whole
// pipe holds while a waiting result is stalled. Write the moduli only when
// the unit is idle.
`default_nettype none

module rns_channel_arithmetic_top import rca_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire req_data_type            req_data,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output rsp_data_type                 rsp_data,
   input  wire logic                    csr_we,
   input  wire logic [RCA_CSR_BITS-1:0] csr_addr,
   input  wire logic [RCA_RES_BITS-1:0] csr_wdata
);

   logic [RCA_RES_BITS-1:0] modulus_ff [RCA_CHANNELS];
   logic [RCA_CNT_BITS-1:0] miu_ff;
   logic [RCA_LANE_LAT-1:0] vld_ff;
   logic [RCA_LANE_LAT-1:0] vld_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   rsp_data_type            rsp_data_ff;
   rsp_data_type            rsp_data_in;
   logic                    advance;
   logic [RCA_RES_BITS-1:0] lhs      [RCA_CHANNELS];
   logic [RCA_RES_BITS-1:0] rhs      [RCA_CHANNELS];
   logic [RCA_RES_BITS-1:0] lane_out [RCA_CHANNELS];
   logic [RCA_RES_BITS-1:0] merged   [RCA_CHANNELS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < RCA_CHANNELS; i++) begin
            modulus_ff[i] <= modulus_reset(i);
         end
         miu_ff <= MODULI_IN_USE_RESET;
      end else if (csr_we) begin
         for (int i = 0; i < RCA_CHANNELS; i++) begin
            if (csr_addr == REG_MODULUS_0 + RCA_CSR_BITS'(i)) begin
               modulus_ff[i] <= csr_wdata;
            end
         end
         if (csr_addr == REG_MODULI_IN_USE) begin
            miu_ff <= csr_wdata[RCA_CNT_BITS-1:0];
         end
      end
   end

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   assign lhs[0] = req_data.lhs_res_0;
   assign lhs[1] = req_data.lhs_res_1;
   assign lhs[2] = req_data.lhs_res_2;
   assign lhs[3] = req_data.lhs_res_3;
   assign rhs[0] = req_data.rhs_res_0;
   assign rhs[1] = req_data.rhs_res_1;
   assign rhs[2] = req_data.rhs_res_2;
   assign rhs[3] = req_data.rhs_res_3;

   genvar g;
   generate
      for (g = 0; g < RCA_CHANNELS; g++) begin : g_lane
         rca_lane #(
            .RES_BITS(RCA_RES_BITS),
            .VAL_BITS(RCA_VAL_BITS),
            .RED_BITS(RCA_RED_BITS)
         ) u_lane (
            .clock   (clock),
            .enable  (advance),
            .op      (req_data.op),
            .value   (req_data.binary_value),
            .lhs     (lhs[g]),
            .rhs     (rhs[g]),
            .modulus (modulus_ff[g]),
            .result  (lane_out[g])
         );
      end
   endgenerate

   // merge: inactive lanes and a zero modulus read as zero
   always_comb begin
      for (int i = 0; i < RCA_CHANNELS; i++) begin
         if ((RCA_CNT_BITS'(i) < miu_ff) && (modulus_ff[i] != '0)) begin
            merged[i] = lane_out[i];
         end else begin
            merged[i] = '0;
         end
      end
      rsp_data_in.out_res_0 = merged[0];
      rsp_data_in.out_res_1 = merged[1];
      rsp_data_in.out_res_2 = merged[2];
      rsp_data_in.out_res_3 = merged[3];
      vld_in       = {vld_ff[RCA_LANE_LAT-2:0], req_valid};
      rsp_valid_in = vld_ff[RCA_LANE_LAT-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> vld_ff[0])
      else $error("accepted request did not enter the pipe");

   a_hold_pipe: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(vld_ff))
      else $error("pipe moved while output stalled");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && (vld_ff == '0))
      else $error("valid state not cleared by reset");

endmodule

`default_nettype wire

>>> tb/rns_channel_arithmetic_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rns_channel_arithmetic_top_tb
// Drives convert/add/subtract/multiply requests through the residue unit
// under several modulus settings, with random idling on both sides, and
// checks every result against a per-lane residue predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module rns_channel_arithmetic_top_tb;
   import rca_pkg::*;

   localparam int PIPE_DRAIN = 60;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   req_data_type            req_data;
   logic                    rsp_valid;
   logic                    rsp_stall;
   rsp_data_type            rsp_data;
   logic                    csr_we;
   logic [RCA_CSR_BITS-1:0] csr_addr;
   logic [RCA_RES_BITS-1:0] csr_wdata;

   rns_channel_arithmetic_top u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   // predictor copy of the configuration
   logic [RCA_RES_BITS-1:0] lane_modulus [RCA_CHANNELS];
   logic [RCA_CNT_BITS-1:0] lanes_active;

   req_data_type pending_reqs [$];
   rsp_data_type expected_residues [$];
   int  mismatch_count;
   bit  quiet_mode;
   bit  sender_hold;
   int  accepted_reqs;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic logic [RCA_RES_BITS-1:0] lane_residue(
      input logic [1:0] op, input logic [RCA_RES_BITS-1:0] m,
      input logic [RCA_VAL_BITS-1:0] value,
      input logic [RCA_RES_BITS-1:0] a, input logic [RCA_RES_BITS-1:0] b);
      logic [63:0] ra, rb, mm, r;
      if (m == '0)
         return '0;
      mm = 64'(m);
      ra = 64'(a) % mm;
      rb = 64'(b) % mm;
      case (op)
         OP_CONVERT:  r = 64'(value) % mm;
         OP_ADD:      r = (ra + rb) % mm;
         OP_SUBTRACT: r = (ra + mm - rb) % mm;
         default:     r = (ra * rb) % mm;
      endcase
      return r[RCA_RES_BITS-1:0];
   endfunction

   function automatic rsp_data_type predict_residues(input req_data_type rq);
      rsp_data_type rs;
      logic [RCA_RES_BITS-1:0] lhs [RCA_CHANNELS];
      logic [RCA_RES_BITS-1:0] rhs [RCA_CHANNELS];
      logic [RCA_RES_BITS-1:0] res [RCA_CHANNELS];
      int active;
      lhs = '{rq.lhs_res_0, rq.lhs_res_1, rq.lhs_res_2, rq.lhs_res_3};
      rhs = '{rq.rhs_res_0, rq.rhs_res_1, rq.rhs_res_2, rq.rhs_res_3};
      active = (lanes_active > RCA_CHANNELS) ? RCA_CHANNELS : lanes_active;
      for (int i = 0; i < RCA_CHANNELS; i++)
         res[i] = (i < active) ?
                  lane_residue(rq.op, lane_modulus[i], rq.binary_value, lhs[i], rhs[i]) : '0;
      rs.out_res_0 = res[0];
      rs.out_res_1 = res[1];
      rs.out_res_2 = res[2];
      rs.out_res_3 = res[3];
      return rs;
   endfunction

   function automatic bit idle_roll();
      return !quiet_mode && ($urandom_range(99) < 13);
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_residues.insert(expected_residues.size(), predict_residues(req_data));
            accepted_reqs++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_reqs.size() > 0 && !sender_hold && !idle_roll()) begin
               req_data  <= pending_reqs.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_residues.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("ERROR: unexpected result %h", rsp_data);
            end else begin
               rsp_data_type exp_rs;
               exp_rs = expected_residues.pop_front();
               if (exp_rs !== rsp_data) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("ERROR: residues expected %h %h %h %h got %h %h %h %h",
                        exp_rs.out_res_0, exp_rs.out_res_1, exp_rs.out_res_2,
                        exp_rs.out_res_3, rsp_data.out_res_0, rsp_data.out_res_1,
                        rsp_data.out_res_2, rsp_data.out_res_3);
               end
            end
         end
         rsp_stall <= idle_roll();
      end
   end

   task automatic write_reg(input logic [RCA_CSR_BITS-1:0] idx,
                            input logic [RCA_RES_BITS-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == REG_MODULI_IN_USE)
         lanes_active = val[RCA_CNT_BITS-1:0];
      else
         lane_modulus[2'(idx - REG_MODULUS_0)] = val;
   endtask

   task automatic drain_all();
      while (pending_reqs.size() > 0 || req_valid || expected_residues.size() > 0)
         @(posedge clock);
      repeat (PIPE_DRAIN) @(posedge clock);
   endtask

   function automatic logic [RCA_RES_BITS-1:0] rand_residue(
      input logic [RCA_RES_BITS-1:0] m);
      case ($urandom_range(9))
         0: return RCA_RES_BITS'($urandom);
         1: return '1;
         2: return '0;
         3: return (m == '0) ? '0 : m - 1'b1;
         default: return (m == '0) ? '0 : RCA_RES_BITS'($urandom_range(m - 1'b1));
      endcase
   endfunction

   function automatic req_data_type rand_req();
      req_data_type rq;
      rq.op = 2'($urandom_range(3));
      case ($urandom_range(3))
         0: rq.binary_value = '1;
         1: rq.binary_value = 32'($urandom_range(70000));
         default: rq.binary_value = $urandom;
      endcase
      rq.lhs_res_0 = rand_residue(lane_modulus[0]);
      rq.lhs_res_1 = rand_residue(lane_modulus[1]);
      rq.lhs_res_2 = rand_residue(lane_modulus[2]);
      rq.lhs_res_3 = rand_residue(lane_modulus[3]);
      rq.rhs_res_0 = rand_residue(lane_modulus[0]);
      rq.rhs_res_1 = rand_residue(lane_modulus[1]);
      rq.rhs_res_2 = rand_residue(lane_modulus[2]);
      rq.rhs_res_3 = rand_residue(lane_modulus[3]);
      return rq;
   endfunction

   task automatic queue_random(input int count);
      for (int i = 0; i < count; i++)
         pending_reqs.insert(pending_reqs.size(), rand_req());
   endtask

   task automatic load_moduli(input logic [RCA_RES_BITS-1:0] m0, m1, m2, m3,
                              input logic [RCA_CNT_BITS-1:0] in_use);
      write_reg(REG_MODULUS_0 + 3'd0, m0);
      write_reg(REG_MODULUS_0 + 3'd1, m1);
      write_reg(REG_MODULUS_0 + 3'd2, m2);
      write_reg(REG_MODULUS_0 + 3'd3, m3);
      write_reg(REG_MODULI_IN_USE, RCA_RES_BITS'(in_use));
   endtask

   initial begin
      req_data_type rq;
      mismatch_count = 0;
      accepted_reqs  = 0;
      quiet_mode     = 1'b0;
      sender_hold    = 1'b0;
      req_valid      = 1'b0;
      req_data       = '0;
      rsp_stall      = 1'b0;
      csr_we         = 1'b0;
      csr_addr       = '0;
      csr_wdata      = '0;
      for (int i = 0; i < RCA_CHANNELS; i++)
         lane_modulus[i] = modulus_reset(i);
      lanes_active = MODULI_IN_USE_RESET;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: every op at field extremes and once at random, with reset moduli
      for (int op = 0; op < 4; op++) begin
         rq = '1;
         rq.op = 2'(op);
         pending_reqs.insert(pending_reqs.size(), rq);
         rq = '0;
         rq.op = 2'(op);
         pending_reqs.insert(pending_reqs.size(), rq);
         rq = rand_req();
         rq.op = 2'(op);
         pending_reqs.insert(pending_reqs.size(), rq);
      end
      // subtract with lhs below rhs, unreduced operands; then an all-ones multiply
      rq = '0;
      rq.op = OP_SUBTRACT;
      rq.rhs_res_0 = 16'd250; rq.rhs_res_1 = 16'd1000;
      rq.lhs_res_2 = 16'd3;   rq.rhs_res_2 = 16'd254;
      rq.lhs_res_3 = 16'd300;
      pending_reqs.insert(pending_reqs.size(), rq);
      rq = '1;
      rq.op = OP_MULTIPLY;
      rq.lhs_res_0 = 16'd250; rq.rhs_res_0 = 16'd250;
      pending_reqs.insert(pending_reqs.size(), rq);
      queue_random(60);
      drain_all();

      // modulus zero and one, lanes beyond RCA_CHANNELS
      load_moduli(16'd0, 16'd1, 16'hFFFF, 16'hFFFE, 3'd7);
      for (int op = 0; op < 4; op++) begin
         rq = '1;
         rq.op = 2'(op);
         pending_reqs.insert(pending_reqs.size(), rq);
      end
      queue_random(120);
      drain_all();

      // no lanes in use
      write_reg(REG_MODULI_IN_USE, 16'd0);
      queue_random(20);
      drain_all();

      // large coprime-ish moduli, partial lanes, a stretch with no idling
      load_moduli(16'hFFFF, 16'hFFFD, 16'hFFFB, 16'd2, 3'd3);
      quiet_mode = 1'b1;
      queue_random(150);
      drain_all();
      quiet_mode = 1'b0;

      // sender pause: hold until everything outstanding is back
      load_moduli(RCA_RES_BITS'($urandom_range(2, 65535)),
                  RCA_RES_BITS'($urandom_range(2, 65535)),
                  RCA_RES_BITS'($urandom_range(2, 65535)),
                  RCA_RES_BITS'($urandom_range(2, 65535)), 3'd1);
      queue_random(100);
      wait (pending_reqs.size() < 50);
      sender_hold = 1'b1;
      while (req_valid || expected_residues.size() > 0)
         @(posedge clock);
      sender_hold = 1'b0;
      drain_all();

      for (int ph = 0; ph < 4; ph++) begin
         load_moduli(RCA_RES_BITS'($urandom_range(2, 65535)),
                     RCA_RES_BITS'($urandom_range(2, 65535)),
                     RCA_RES_BITS'($urandom_range(2, 65535)),
                     RCA_RES_BITS'($urandom_range(2, 300)),
                     3'($urandom_range(1, 4)));
         queue_random(100);
         drain_all();
      end

      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #5ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

`default_nettype wire
